FILE: design/periodic_timer_bank_defines.svh
// ----------------------------------------------------------------------------
// periodic timer bank assertion macros
// shared assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define PTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define PTB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PTB_ASSERT(lbl, prop, msg)
`define PTB_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: design/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// types and constants shared by the periodic timer bank modules
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int INTERVAL_W     = 16;
  localparam int STATUS_W       = 2;
  localparam int IDX_OUT_W      = 3;
  localparam int USED_W         = 4;
  localparam int MAX_FIRES      = 8;
  localparam int FIRE_CNT_W     = 4;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_SERVICE = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  add;
    logic                  tick;
    logic                  shift;
    logic [INTERVAL_W-1:0] interval;
    logic                  has_handler;
  } cell_ctl_t;

endpackage

FILE: design/ptb_cell.sv
// ----------------------------------------------------------------------------
// ptb_cell
// one timer slot: reload value, down count, pending mark and handler flag;
// passes the fill marker and the service token on to its neighbor
// ----------------------------------------------------------------------------
module ptb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptb_pkg::cell_ctl_t ctl_i,
  input  logic               prev_used_i,
  output logic               used_o,
  input  logic               token_i,
  output logic               token_o,
  output logic               fire_o
);
  import ptb_pkg::*;

  logic                  used_q, used_d;
  logic                  token_q, token_d;
  logic                  pend_q, pend_d;
  logic                  hdl_q, hdl_d;
  logic [INTERVAL_W-1:0] reload_q, reload_d;
  logic [INTERVAL_W-1:0] count_q, count_d;
  logic                  take;

  assign take = ctl_i.add && !used_q && prev_used_i;

  always_comb begin
    used_d   = used_q;
    token_d  = token_q;
    pend_d   = pend_q;
    hdl_d    = hdl_q;
    reload_d = reload_q;
    count_d  = count_q;
    if (take) begin
      used_d   = 1'b1;
      pend_d   = 1'b0;
      hdl_d    = ctl_i.has_handler;
      reload_d = ctl_i.interval;
      count_d  = ctl_i.interval;
    end
    if (ctl_i.tick && used_q) begin
      if (count_q != '0) begin
        count_d = count_q - INTERVAL_W'(1);
      end else begin
        count_d = reload_q;
        pend_d  = 1'b1;
      end
    end
    if (ctl_i.shift) begin
      token_d = token_i;
      if (token_q) begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      token_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      used_q  <= used_d;
      token_q <= token_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdl_q    <= hdl_d;
    reload_q <= reload_d;
    count_q  <= count_d;
  end

  assign used_o  = used_q;
  assign token_o = token_q;
  assign fire_o  = token_q && used_q && pend_q && hdl_q;

endmodule

FILE: design/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// bank of periodic down-counting timers built as a chain of slot cells
// ----------------------------------------------------------------------------
// An add or tick transaction gives one result; all slots update their counts
// in parallel on a tick. A service transaction passes a token down the cell
// chain one slot per cycle, pausing while a firing waits on a busy output
// register; each firing slot gives one result, up to MAX_FIRES, and the last
// result (status none if no slot fired) follows once the token leaves the
// final cell. New transactions are taken only while no service walk is open
// and the output register is free or being emptied.
module periodic_timer_bank #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [ptb_pkg::INTERVAL_W-1:0] interval_i,
  input  logic                           has_handler_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ptb_pkg::STATUS_W-1:0]   status_o,
  output logic [ptb_pkg::IDX_OUT_W-1:0]  timer_index_o,
  output logic                           fired_o,
  output logic [ptb_pkg::USED_W-1:0]     timers_used_o,
  output logic                           last_o
);
  import ptb_pkg::*;

`include "periodic_timer_bank_defines.svh"

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       scan_idx_q, scan_idx_d;
  logic [FIRE_CNT_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic                   held_v_q, held_v_d;
  logic [IDX_W-1:0]       held_idx_q, held_idx_d;
  logic [CNT_W-1:0]       slots_q, slots_d;

  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [IDX_OUT_W-1:0]   idx_q, idx_d;
  logic                   fired_q, fired_d;
  logic [USED_W-1:0]      used_q, used_d;
  logic                   last_q, last_d;

  cell_ctl_t              ctl;
  logic                   tok_start;
  logic                   out_free;
  logic                   accept;
  logic                   full;
  logic                   fire_any;
  logic                   fire_eff;
  logic                   adv;
  logic [31:0]            slots_ext;
  logic [31:0]            slots_inc_ext;
  logic [31:0]            held_ext;

  logic [NUM_TIMERS:0]    used_chain;
  logic [NUM_TIMERS:0]    token_chain;
  logic [NUM_TIMERS-1:0]  fire_vec;

  assign used_chain[0]  = 1'b1;
  assign token_chain[0] = tok_start;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    ptb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_used_i (used_chain[g]),
      .used_o      (used_chain[g+1]),
      .token_i     (token_chain[g]),
      .token_o     (token_chain[g+1]),
      .fire_o      (fire_vec[g])
    );
  end

  assign out_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o    = !((state_q == S_IDLE) && out_free);
  assign accept        = in_valid_i && !in_stall_o;
  assign full          = (slots_q == CNT_W'(NUM_TIMERS));
  assign fire_any      = |fire_vec;
  assign fire_eff      = fire_any && (fire_cnt_q < FIRE_CNT_W'(MAX_FIRES));
  assign slots_ext     = 32'(slots_q);
  assign slots_inc_ext = 32'(slots_q) + 32'd1;
  assign held_ext      = 32'(held_idx_q);

  always_comb begin
    state_d         = state_q;
    scan_idx_d      = scan_idx_q;
    fire_cnt_d      = fire_cnt_q;
    held_v_d        = held_v_q;
    held_idx_d      = held_idx_q;
    slots_d         = slots_q;
    out_valid_d     = out_valid_q && out_stall_i;
    status_d        = status_q;
    idx_d           = idx_q;
    fired_d         = fired_q;
    used_d          = used_q;
    last_d          = last_q;
    ctl.add         = 1'b0;
    ctl.tick        = 1'b0;
    ctl.shift       = 1'b0;
    ctl.interval    = interval_i;
    ctl.has_handler = has_handler_i;
    tok_start       = 1'b0;
    adv             = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_ADD: begin
              out_valid_d = 1'b1;
              fired_d     = 1'b0;
              last_d      = 1'b1;
              if (full) begin
                status_d = ST_FULL;
                idx_d    = '0;
                used_d   = slots_ext[USED_W-1:0];
              end else begin
                ctl.add  = 1'b1;
                slots_d  = slots_q + CNT_W'(1);
                status_d = ST_OK;
                idx_d    = slots_ext[IDX_OUT_W-1:0];
                used_d   = slots_inc_ext[USED_W-1:0];
              end
            end
            ACT_TICK: begin
              ctl.tick    = 1'b1;
              out_valid_d = 1'b1;
              status_d    = ST_OK;
              idx_d       = '0;
              fired_d     = 1'b0;
              used_d      = slots_ext[USED_W-1:0];
              last_d      = 1'b1;
            end
            ACT_SERVICE: begin
              ctl.shift  = 1'b1;
              tok_start  = 1'b1;
              state_d    = S_SCAN;
              scan_idx_d = '0;
              fire_cnt_d = '0;
              held_v_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        adv       = !(fire_eff && held_v_q && !out_free);
        ctl.shift = adv;
        if (fire_eff && adv) begin
          if (held_v_q) begin
            out_valid_d = 1'b1;
            status_d    = ST_OK;
            idx_d       = held_ext[IDX_OUT_W-1:0];
            fired_d     = 1'b1;
            used_d      = slots_ext[USED_W-1:0];
            last_d      = 1'b0;
          end
          held_v_d   = 1'b1;
          held_idx_d = scan_idx_q;
          fire_cnt_d = fire_cnt_q + FIRE_CNT_W'(1);
        end
        if (adv) begin
          if (scan_idx_q == IDX_W'(NUM_TIMERS - 1)) begin
            state_d = S_FLUSH;
          end else begin
            scan_idx_d = scan_idx_q + IDX_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          used_d      = slots_ext[USED_W-1:0];
          last_d      = 1'b1;
          if (held_v_q) begin
            status_d = ST_OK;
            idx_d    = held_ext[IDX_OUT_W-1:0];
            fired_d  = 1'b1;
          end else begin
            status_d = ST_NONE;
            idx_d    = '0;
            fired_d  = 1'b0;
          end
          held_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_idx_q  <= '0;
      fire_cnt_q  <= '0;
      held_v_q    <= 1'b0;
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      fire_cnt_q  <= fire_cnt_d;
      held_v_q    <= held_v_d;
      slots_q     <= slots_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_idx_q <= held_idx_d;
    status_q   <= status_d;
    idx_q      <= idx_d;
    fired_q    <= fired_d;
    used_q     <= used_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign timer_index_o = idx_q;
  assign fired_o       = fired_q;
  assign timers_used_o = used_q;
  assign last_o        = last_q;

  // transactions only enter while no service walk is open
  `PTB_ASSERT(a_accept_idle, accept |-> state_q == S_IDLE, "transaction accepted mid service")
  // a held firing only exists during a service walk
  `PTB_ASSERT_NEVER(a_held_idle, held_v_q && state_q == S_IDLE, "held firing left over")
  // at most one cell holds the service token
  `PTB_ASSERT(a_token_onehot, $onehot0(token_chain[NUM_TIMERS:1]), "service token duplicated")
  // the slot count never passes the bank size
  `PTB_ASSERT(a_slots_range, slots_q <= CNT_W'(NUM_TIMERS), "slot count overflow")

endmodule
